>>> rtl/tgbc_pkg.sv
// Shared constants, types and helper functions of the tile grid collision block.
package tgbc_pkg;

    // Grid geometry and fixed-point format.
    localparam int GRID_COLS  = 16;
    localparam int GRID_ROWS  = 15;
    localparam int TILE_SHIFT = 4;
    localparam int FRAC_BITS  = 4;

    localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;
    localparam int COL_W      = $clog2(GRID_COLS);
    localparam int ROW_W      = $clog2(GRID_ROWS);
    localparam int ADDR_W     = $clog2(GRID_CELLS);

    // Field widths of the stream items.
    localparam int POS_W      = 12;
    localparam int SUM_W      = POS_W + 1;
    localparam int WCOL_W     = 4;
    localparam int WROW_W     = 4;
    localparam int TILE_W     = 8;
    localparam int HIT_COL_W  = 4;
    localparam int HIT_ROW_W  = 4;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 16;

    localparam logic [TILE_W-1:0] EMPTY_TILE = 8'hFF;
    // A tile is passable when both of its low code bits are set.
    localparam logic [1:0] PASS_BITS = 2'b11;

    // Item kinds carried in the input tuser.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Command queue between the front and the back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic              kind;
        logic              in_grid;
        logic [COL_W-1:0]  col_lo;
        logic [COL_W-1:0]  col_hi;
        logic [ROW_W-1:0]  row_lo;
        logic [ROW_W-1:0]  row_hi;
        logic [TILE_W-1:0] code;
    } cmd_t;

    typedef struct packed {
        logic push_ok;
        logic pop_ok;
    } fifo_stat_t;

    // Floor of a fixed-point coordinate to a tile index, clamped to the grid.
    function automatic int unsigned tile_index(input logic [SUM_W-1:0] fixed,
                                               input int unsigned limit);
        int unsigned t;
        t = 32'(fixed) >> (FRAC_BITS + TILE_SHIFT);
        return (t > limit - 1) ? (limit - 1) : t;
    endfunction

    // Row-major address of a grid cell.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                    input logic [ROW_W-1:0] row);
        return ADDR_W'(32'(row) * GRID_COLS + 32'(col));
    endfunction

endpackage

>>> rtl/tgbc_ram.sv
// Generic single-port RAM with registered read data.
module tgbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tgbc_front.sv
// Input side: accepts items, classifies them and works out the covered tile range.
module tgbc_front
    import tgbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tuser,
    output logic                 cmd_valid,
    output cmd_t                 cmd,
    input  logic                 cmd_full
);

    logic              cmd_valid_reg;
    logic              cmd_valid_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic              accept;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  box_width;
    logic [POS_W-1:0]  box_height;
    logic [WCOL_W-1:0] write_col;
    logic [WROW_W-1:0] write_row;
    logic [TILE_W-1:0] tile_code;

    assign pos_x      = s_axis_tdata[11:0];
    assign pos_y      = s_axis_tdata[23:12];
    assign box_width  = s_axis_tdata[35:24];
    assign box_height = s_axis_tdata[47:36];
    assign write_col  = s_axis_tdata[51:48];
    assign write_row  = s_axis_tdata[55:52];
    assign tile_code  = s_axis_tdata[63:56];

    assign s_axis_tready = !cmd_valid_reg || !cmd_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        cmd_next.kind = s_axis_tuser;
        cmd_next.code = tile_code;
        if (s_axis_tuser == KIND_WRITE)
        begin
            cmd_next.in_grid = (32'(write_col) < GRID_COLS) && (32'(write_row) < GRID_ROWS);
            cmd_next.col_lo  = COL_W'(write_col);
            cmd_next.col_hi  = COL_W'(write_col);
            cmd_next.row_lo  = ROW_W'(write_row);
            cmd_next.row_hi  = ROW_W'(write_row);
        end
        else
        begin
            // Sums are formed one bit wider so that they never wrap.
            cmd_next.in_grid = 1'b1;
            cmd_next.col_lo  = COL_W'(tile_index(SUM_W'(pos_x), GRID_COLS));
            cmd_next.col_hi  = COL_W'(tile_index(SUM_W'(pos_x) + SUM_W'(box_width), GRID_COLS));
            cmd_next.row_lo  = ROW_W'(tile_index(SUM_W'(pos_y), GRID_ROWS));
            cmd_next.row_hi  = ROW_W'(tile_index(SUM_W'(pos_y) + SUM_W'(box_height), GRID_ROWS));
        end
    end

    assign cmd_valid_next = accept || (cmd_valid_reg && cmd_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

>>> rtl/tgbc_fifo.sv
// Short command queue between the front and the back.
module tgbc_fifo
    import tgbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  cmd_t       push_cmd,
    input  logic       pop,
    output cmd_t       pop_cmd,
    output fifo_stat_t stat
);

    cmd_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign pop_cmd      = entry_reg[rd_ptr_reg];
    assign stat.push_ok = (count_reg != (FIFO_AW+1)'(FIFO_DEPTH));
    assign stat.pop_ok  = (count_reg != '0);

    assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg < (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("command queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("command queue underflow");

endmodule

>>> rtl/tgbc_back.sv
// Back side: applies tile writes and scans the covered tiles of a query.
module tgbc_back
    import tgbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  cmd_t                  cmd,
    output logic                  cmd_pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tuser
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                  state_reg;
    logic                  state_next;
    logic [COL_W-1:0]      cur_c_reg;
    logic [ROW_W-1:0]      cur_r_reg;
    logic [COL_W-1:0]      c_hi_reg;
    logic [ROW_W-1:0]      r_lo_reg;
    logic [ROW_W-1:0]      r_hi_reg;
    logic                  pend_reg;
    logic                  pend_last_reg;
    logic [COL_W-1:0]      pc_reg;
    logic [ROW_W-1:0]      pr_reg;
    logic                  rd_valid_reg;
    logic [GRID_CELLS-1:0] valid_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_hit_reg;
    logic [TILE_W-1:0]     out_tile_reg;
    logic [HIT_COL_W-1:0]  out_col_reg;
    logic [HIT_ROW_W-1:0]  out_row_reg;

    logic                  start_write;
    logic                  start_query;
    logic                  ram_we;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     ram_addr;
    logic [TILE_W-1:0]     ram_rdata;
    logic [TILE_W-1:0]     tile_now;
    logic                  solid;
    logic                  finish;
    logic                  issue;
    logic                  row_end;

    assign start_write = (state_reg == ST_IDLE) && cmd_valid && (cmd.kind == KIND_WRITE);
    assign start_query = (state_reg == ST_IDLE) && cmd_valid && (cmd.kind == KIND_QUERY)
                         && !out_valid_reg;
    assign cmd_pop     = start_write || start_query;

    assign ram_we   = start_write && cmd.in_grid;
    assign wr_addr  = cell_addr(cmd.col_lo, cmd.row_lo);
    assign rd_addr  = cell_addr(cur_c_reg, cur_r_reg);
    assign ram_addr = ram_we ? wr_addr : rd_addr;

    tgbc_ram #(
        .WIDTH (TILE_W),
        .DEPTH (GRID_CELLS)
    ) u_tile_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (cmd.code),
        .rdata (ram_rdata)
    );

    // Cells never written since reset read as empty.
    assign tile_now = rd_valid_reg ? ram_rdata : EMPTY_TILE;
    assign solid    = pend_reg && (tile_now[1:0] != PASS_BITS);
    assign finish   = (state_reg == ST_SCAN) && (solid || (pend_reg && pend_last_reg));
    assign issue    = (state_reg == ST_SCAN) && !finish;
    assign row_end  = (cur_r_reg == r_hi_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_query)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = finish || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rd_valid_reg  <= valid_reg[ram_addr];
            if (ram_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (issue)
            begin
                pend_reg      <= 1'b1;
                pend_last_reg <= (cur_c_reg == c_hi_reg) && row_end;
            end
            else
            begin
                pend_reg      <= 1'b0;
                pend_last_reg <= 1'b0;
            end
        end
    end

    // Scan position: columns outer, rows inner.
    always_ff @(posedge clk)
    begin
        if (start_query)
        begin
            cur_c_reg <= cmd.col_lo;
            cur_r_reg <= cmd.row_lo;
            c_hi_reg  <= cmd.col_hi;
            r_lo_reg  <= cmd.row_lo;
            r_hi_reg  <= cmd.row_hi;
        end
        else if (issue)
        begin
            pc_reg <= cur_c_reg;
            pr_reg <= cur_r_reg;
            if (row_end)
            begin
                cur_r_reg <= r_lo_reg;
                cur_c_reg <= cur_c_reg + 1'b1;
            end
            else
            begin
                cur_r_reg <= cur_r_reg + 1'b1;
            end
        end
        if (finish)
        begin
            out_hit_reg <= solid;
            if (solid)
            begin
                out_tile_reg <= tile_now;
                out_col_reg  <= HIT_COL_W'(32'(pc_reg));
                out_row_reg  <= HIT_ROW_W'(32'(pr_reg));
            end
            else
            begin
                out_tile_reg <= EMPTY_TILE;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_row_reg, out_col_reg, out_tile_reg};
    assign m_axis_tuser  = out_hit_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_reg)
        else $error("tile read pending outside a scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (pc_reg <= c_hi_reg) && (pr_reg <= r_hi_reg) && (pr_reg >= r_lo_reg))
        else $error("scan left the covered tile range");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_SCAN)
        else $error("result raised without a finished scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_hit_reg |->
            (out_tile_reg == EMPTY_TILE) && (out_col_reg == '0) && (out_row_reg == '0))
        else $error("miss result carries tile data");

endmodule

>>> rtl/tile_grid_box_collision.sv
// Top level of the tile grid with box collision queries.
//
// Input stream s_axis: tuser selects the item kind (0 write one tile, 1 query
// a box). A write stores tile_code at write_col and write_row and gives no
// result; writes outside the grid are dropped. A query returns one result on
// m_axis: tuser is the hit flag, tdata holds the first solid tile in column
// major scan order with its column and row, or an empty code with zero place.
// A query scan reads the covered tiles up to and including the first solid
// one (all covered tiles on a miss), one tile per cycle from the single port
// of the tile RAM. A four-entry command queue lets the input keep taking
// items while a scan runs or a result waits.
// A new query starts only once the previous result has been transferred, so a
// stalled receiver backs up the queue and then the input. Reset empties the
// grid at once through per-cell valid bits; no clearing pass is needed.
module tile_grid_box_collision
    import tgbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pos_x, pos_y, box_width, box_height, write_col, write_row, tile_code
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // found_tile, hit_col, hit_row
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // hit
    output logic                  m_axis_tuser
);

    logic       front_valid;
    cmd_t       front_cmd;
    cmd_t       queue_cmd;
    fifo_stat_t queue_stat;
    logic       queue_push;
    logic       queue_pop;

    tgbc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (front_valid),
        .cmd           (front_cmd),
        .cmd_full      (!queue_stat.push_ok)
    );

    assign queue_push = front_valid && queue_stat.push_ok;

    tgbc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (queue_push),
        .push_cmd (front_cmd),
        .pop      (queue_pop),
        .pop_cmd  (queue_cmd),
        .stat     (queue_stat)
    );

    tgbc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (queue_stat.pop_ok),
        .cmd           (queue_cmd),
        .cmd_pop       (queue_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
